FILE: hdl/marker_vertex_generator_top_defines.svh
// Assertion macros shared by the marker vertex generator checkers.
// Each macro expects a signal named clock in the using scope; all but MVG_ASSERT_RESET also reset.
`ifndef MARKER_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define MARKER_VERTEX_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define MVG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MVG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked during reset.
`define MVG_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mvg_pkg.sv
// Package for the marker vertex generator: codes, shared types and the
// fixed-point sine and cosine used to build the glyph tables. No dependencies.
`default_nettype none

package mvg_pkg;

   // Marker type register codes.
   localparam logic [3:0] MT_DOT      = 4'd0;
   localparam logic [3:0] MT_PLUS     = 4'd1;
   localparam logic [3:0] MT_ASTERISK = 4'd2;
   localparam logic [3:0] MT_CROSS    = 4'd3;
   localparam logic [3:0] MT_CIRCLE   = 4'd4;
   localparam logic [3:0] MT_TRIANGLE = 4'd5;
   localparam logic [3:0] MT_SQUARE   = 4'd6;
   localparam logic [3:0] MT_PENTAGON = 4'd7;
   localparam logic [3:0] MT_HEXAGON  = 4'd8;

   // Primitive kind codes on the result channel.
   localparam logic [1:0] PK_POINT = 2'd0;
   localparam logic [1:0] PK_LINE  = 2'd1;
   localparam logic [1:0] PK_FAN   = 2'd2;
   localparam logic [1:0] PK_RSVD  = 2'd3;

   // Register indexes on the configuration port.
   localparam logic REG_MARKER_TYPE = 1'b0;
   localparam logic REG_MARKER_SIZE = 1'b1;

   localparam logic [3:0]  MARKER_TYPE_RESET = MT_DOT;
   localparam logic [23:0] MARKER_SIZE_RESET = 24'd65536;

   localparam int CIRCLE_SIDES_DEFAULT = 40;
   localparam int QUEUE_DEPTH          = 4;

   // 1/1.414 in Q0.16 and its rounding term.
   localparam logic [15:0] INV_1414_Q16 = 16'd46348;
   localparam logic [38:0] DIAG_ROUND   = 39'd32768;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // One marker center waiting in the queue.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [3:0]         mtype;
   } mvg_item_type;

   // Scale values derived from the size register.
   typedef struct packed {
      logic [23:0] size;
      logic [22:0] half;
      logic [22:0] diag;
   } mvg_cfg_type;

   // Q1.15 cosine and sine of one fan angle.
   typedef struct packed {
      logic signed [15:0] cosv;
      logic signed [15:0] sinv;
   } trig_pair_type;

   // One Horner term: 1 - sub, floored at zero.
   function automatic logic [63:0] horner_clamp(input logic [63:0] sub);
      return (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
   endfunction

   // Q30 value rounded into Q1.15, capped at the largest positive code.
   function automatic logic signed [15:0] to_q15(input logic [63:0] v);
      logic [63:0] r;
      r = (v + 64'd16384) >> 15;
      return (r > 64'd32767) ? 16'sd32767 : 16'(r);
   endfunction

   // Cosine and sine of phase p in 1/65536 turn. Only called with constant
   // arguments, so it folds into table constants.
   function automatic trig_pair_type trig_q15(input logic [15:0] p);
      logic [63:0]        r;
      logic [63:0]        u;
      logic [63:0]        u2;
      logic [63:0]        t;
      logic signed [15:0] c;
      logic signed [15:0] s;
      trig_pair_type      res;
      r  = {50'd0, p[13:0]};
      u  = (r * HALF_PI_Q30) >> 14;
      u2 = (u * u) >> 30;
      // Sine series.
      t = Q30_ONE;
      t = horner_clamp(((u2 * t) >> 30) / 64'd110);
      t = horner_clamp(((u2 * t) >> 30) / 64'd72);
      t = horner_clamp(((u2 * t) >> 30) / 64'd42);
      t = horner_clamp(((u2 * t) >> 30) / 64'd20);
      t = horner_clamp(((u2 * t) >> 30) / 64'd6);
      s = to_q15((u * t) >> 30);
      // Cosine series.
      t = Q30_ONE;
      t = horner_clamp(((u2 * t) >> 30) / 64'd132);
      t = horner_clamp(((u2 * t) >> 30) / 64'd90);
      t = horner_clamp(((u2 * t) >> 30) / 64'd56);
      t = horner_clamp(((u2 * t) >> 30) / 64'd30);
      t = horner_clamp(((u2 * t) >> 30) / 64'd12);
      t = horner_clamp(((u2 * t) >> 30) / 64'd2);
      c = to_q15(t);
      // Rotate by quadrant.
      case (p[15:14])
         2'd0: begin
            res.cosv = c;
            res.sinv = s;
         end
         2'd1: begin
            res.cosv = -s;
            res.sinv = c;
         end
         2'd2: begin
            res.cosv = -c;
            res.sinv = -s;
         end
         default: begin
            res.cosv = s;
            res.sinv = -c;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/mvg_front.sv
// Front end of the marker vertex generator: configuration registers,
// input acceptance and marker type screening. Uses mvg_pkg.
`default_nettype none

module mvg_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Configuration port
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   // Input channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [31:0]   req_point_x,
   input  wire logic signed [31:0]   req_point_y,
   // Queue side
   input  wire logic                 queue_full,
   output logic                      push,
   output mvg_pkg::mvg_item_type     push_item,
   output mvg_pkg::mvg_cfg_type      cfg
);

   logic [3:0]  mtype_ff;
   logic [3:0]  mtype_in;
   logic [23:0] size_ff;
   logic [23:0] size_in;
   logic [22:0] diag_ff;
   logic [22:0] diag_in;
   logic [22:0] half;
   logic [38:0] diag_prod;
   logic        csr_write;
   logic        accept;
   logic        type_ok;

   // Register writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mtype_in = mtype_ff;
      size_in  = size_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            mvg_pkg::REG_MARKER_TYPE: mtype_in = csr_pwdata[3:0];
            mvg_pkg::REG_MARKER_SIZE: size_in  = csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (csr_paddr[2])
         mvg_pkg::REG_MARKER_TYPE: csr_prdata = {28'd0, mtype_ff};
         mvg_pkg::REG_MARKER_SIZE: csr_prdata = {8'd0, size_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // Half size and diagonal offset, refreshed every cycle from the size.
   assign half      = size_ff[23:1];
   assign diag_prod = 39'(half) * 39'(mvg_pkg::INV_1414_Q16) + mvg_pkg::DIAG_ROUND;
   assign diag_in   = diag_prod[38:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         mtype_ff <= mvg_pkg::MARKER_TYPE_RESET;
         size_ff  <= mvg_pkg::MARKER_SIZE_RESET;
      end else begin
         mtype_ff <= mtype_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff <= diag_in;
   end

   assign cfg.size = size_ff;
   assign cfg.half = half;
   assign cfg.diag = diag_ff;

   // Accept while the queue has room; unused type codes are dropped here.
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign type_ok   = (mtype_ff <= mvg_pkg::MT_HEXAGON);
   assign push      = accept && type_ok;

   assign push_item.x     = req_point_x;
   assign push_item.y     = req_point_y;
   assign push_item.mtype = mtype_ff;

endmodule

`default_nettype wire

FILE: hdl/mvg_queue.sv
// Short queue of accepted markers between the front and back ends.
// Uses mvg_pkg for the item type and depth.
`default_nettype none

module mvg_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mvg_pkg::mvg_item_type push_item,
   input  wire logic                 pop,
   output mvg_pkg::mvg_item_type     head_item,
   output logic                      head_valid,
   output logic                      full
);

   localparam int DEPTH = mvg_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   mvg_pkg::mvg_item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CW'(DEPTH));
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/mvg_back.sv
// Back end of the marker vertex generator: vertex sequencer, scaling
// multipliers, saturating add and the result register. Uses mvg_pkg.
`default_nettype none

module mvg_back #(
   parameter int CIRCLE_SIDES = mvg_pkg::CIRCLE_SIDES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mvg_pkg::mvg_item_type head_item,
   input  wire logic                  head_valid,
   output logic                       pop,
   input  wire mvg_pkg::mvg_cfg_type  cfg,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [31:0]         rsp_vert_x,
   output logic signed [31:0]         rsp_vert_y,
   output logic [1:0]                 rsp_prim_kind,
   output logic                       rsp_last_vertex
);

   localparam int JW = $clog2(CIRCLE_SIDES);
   localparam int CW = $clog2(CIRCLE_SIDES + 1);
   localparam int POLY_MIN = 3;
   localparam int POLY_NUM = 4;
   localparam int POLY_MAX = 8;

   // Fan angle tables, folded to constants at elaboration.
   mvg_pkg::trig_pair_type circ_trig [CIRCLE_SIDES];
   mvg_pkg::trig_pair_type poly_trig [POLY_NUM][POLY_MAX];

   for (genvar gj = 0; gj < CIRCLE_SIDES; gj++) begin : g_circ
      localparam int PH = ((2 * gj + 1) * 65536) / (2 * CIRCLE_SIDES);
      assign circ_trig[gj] = mvg_pkg::trig_q15(16'(PH));
   end

   for (genvar gk = 0; gk < POLY_NUM; gk++) begin : g_poly
      for (genvar gj = 0; gj < POLY_MAX; gj++) begin : g_vert
         if (gj < gk + POLY_MIN) begin : g_used
            localparam int PH = ((2 * gj + 1) * 65536) / (2 * (gk + POLY_MIN));
            assign poly_trig[gk][gj] = mvg_pkg::trig_q15(16'(PH));
         end else begin : g_unused
            assign poly_trig[gk][gj] = '0;
         end
      end
   end

   // Pipeline advance: everything moves when the result register frees up.
   logic adv;
   logic out_v_ff;
   assign adv = !out_v_ff || !rsp_stall;

   // ---------------- Sequencer and offset selection ----------------
   logic [JW-1:0]          j_ff;
   logic [JW-1:0]          j_in;
   logic [CW-1:0]          vcount;
   logic                   is_last;
   logic [1:0]             poly_sel;
   logic signed [24:0]     hp;
   logic signed [24:0]     sp;
   logic signed [24:0]     dx_sel;
   logic signed [24:0]     dy_sel;
   logic [1:0]             kind_sel;
   logic                   fan_sel;
   mvg_pkg::trig_pair_type trig_sel;

   assign hp       = $signed({2'b00, cfg.half});
   assign sp       = $signed({2'b00, cfg.diag});
   assign poly_sel = 2'(head_item.mtype - mvg_pkg::MT_TRIANGLE);

   // Vertex count of the marker at the queue head.
   always_comb begin
      case (head_item.mtype)
         mvg_pkg::MT_DOT:      vcount = CW'(1);
         mvg_pkg::MT_PLUS:     vcount = CW'(4);
         mvg_pkg::MT_ASTERISK: vcount = CW'(8);
         mvg_pkg::MT_CROSS:    vcount = CW'(4);
         mvg_pkg::MT_CIRCLE:   vcount = CW'(CIRCLE_SIDES);
         mvg_pkg::MT_TRIANGLE: vcount = CW'(3);
         mvg_pkg::MT_SQUARE:   vcount = CW'(4);
         mvg_pkg::MT_PENTAGON: vcount = CW'(5);
         default:              vcount = CW'(6);
      endcase
   end

   assign is_last = (CW'(j_ff) == vcount - 1'b1);
   assign pop     = adv && head_valid && is_last;

   always_comb begin
      j_in = j_ff;
      if (adv && head_valid) begin
         j_in = is_last ? '0 : j_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else begin
         j_ff <= j_in;
      end
   end

   // Offsets for the line glyphs and the fan table lookup.
   always_comb begin
      dx_sel   = '0;
      dy_sel   = '0;
      kind_sel = mvg_pkg::PK_LINE;
      fan_sel  = 1'b0;
      trig_sel = poly_trig[poly_sel][j_ff[2:0]];
      case (head_item.mtype)
         mvg_pkg::MT_DOT: begin
            kind_sel = mvg_pkg::PK_POINT;
         end
         mvg_pkg::MT_PLUS, mvg_pkg::MT_ASTERISK: begin
            case (j_ff[2:0])
               3'd0: dx_sel = -hp;
               3'd1: dx_sel = hp;
               3'd2: dy_sel = -hp;
               3'd3: dy_sel = hp;
               3'd4: begin
                  dx_sel = -sp;
                  dy_sel = sp;
               end
               3'd5: begin
                  dx_sel = sp;
                  dy_sel = -sp;
               end
               3'd6: begin
                  dx_sel = -sp;
                  dy_sel = -sp;
               end
               default: begin
                  dx_sel = sp;
                  dy_sel = sp;
               end
            endcase
         end
         mvg_pkg::MT_CROSS: begin
            case (j_ff[1:0])
               2'd0: begin
                  dx_sel = -hp;
                  dy_sel = hp;
               end
               2'd1: begin
                  dx_sel = hp;
                  dy_sel = -hp;
               end
               2'd2: begin
                  dx_sel = -hp;
                  dy_sel = -hp;
               end
               default: begin
                  dx_sel = hp;
                  dy_sel = hp;
               end
            endcase
         end
         mvg_pkg::MT_CIRCLE: begin
            kind_sel = mvg_pkg::PK_FAN;
            fan_sel  = 1'b1;
            trig_sel = circ_trig[j_ff];
         end
         default: begin
            kind_sel = mvg_pkg::PK_FAN;
            fan_sel  = 1'b1;
         end
      endcase
   end

   // ---------------- Stage A: selected vertex ----------------
   logic                   sa_v_ff;
   logic signed [31:0]     sa_x_ff;
   logic signed [31:0]     sa_y_ff;
   logic [1:0]             sa_kind_ff;
   logic                   sa_last_ff;
   logic                   sa_fan_ff;
   logic signed [24:0]     sa_dx_ff;
   logic signed [24:0]     sa_dy_ff;
   mvg_pkg::trig_pair_type sa_trig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_v_ff <= 1'b0;
      end else if (adv) begin
         sa_v_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_x_ff    <= head_item.x;
         sa_y_ff    <= head_item.y;
         sa_kind_ff <= kind_sel;
         sa_last_ff <= is_last;
         sa_fan_ff  <= fan_sel;
         sa_dx_ff   <= dx_sel;
         sa_dy_ff   <= dy_sel;
         sa_trig_ff <= trig_sel;
      end
   end

   // ---------------- Stage B: size times trig magnitude ----------------
   logic               sb_v_ff;
   logic signed [31:0] sb_x_ff;
   logic signed [31:0] sb_y_ff;
   logic [1:0]         sb_kind_ff;
   logic               sb_last_ff;
   logic               sb_fan_ff;
   logic signed [24:0] sb_dx_ff;
   logic signed [24:0] sb_dy_ff;
   logic [38:0]        sb_mx_ff;
   logic [38:0]        sb_my_ff;
   logic               sb_nx_ff;
   logic               sb_ny_ff;
   logic [14:0]        abs_c;
   logic [14:0]        abs_s;

   assign abs_c = sa_trig_ff.cosv[15] ? 15'(-sa_trig_ff.cosv) : sa_trig_ff.cosv[14:0];
   assign abs_s = sa_trig_ff.sinv[15] ? 15'(-sa_trig_ff.sinv) : sa_trig_ff.sinv[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_v_ff <= 1'b0;
      end else if (adv) begin
         sb_v_ff <= sa_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_x_ff    <= sa_x_ff;
         sb_y_ff    <= sa_y_ff;
         sb_kind_ff <= sa_kind_ff;
         sb_last_ff <= sa_last_ff;
         sb_fan_ff  <= sa_fan_ff;
         sb_dx_ff   <= sa_dx_ff;
         sb_dy_ff   <= sa_dy_ff;
         sb_mx_ff   <= 39'(cfg.size) * 39'(abs_c);
         sb_my_ff   <= 39'(cfg.size) * 39'(abs_s);
         sb_nx_ff   <= sa_trig_ff.cosv[15];
         sb_ny_ff   <= sa_trig_ff.sinv[15];
      end
   end

   // ---------------- Stage C: round, add, saturate ----------------
   logic [38:0]        rx;
   logic [38:0]        ry;
   logic signed [25:0] fx;
   logic signed [25:0] fy;
   logic signed [25:0] offx;
   logic signed [25:0] offy;
   logic signed [32:0] sumx;
   logic signed [32:0] sumy;
   logic signed [31:0] satx;
   logic signed [31:0] saty;

   assign rx = sb_mx_ff + 39'd16384;
   assign ry = sb_my_ff + 39'd16384;
   assign fx = sb_nx_ff ? -$signed({2'b00, rx[38:15]}) : $signed({2'b00, rx[38:15]});
   assign fy = sb_ny_ff ? -$signed({2'b00, ry[38:15]}) : $signed({2'b00, ry[38:15]});

   assign offx = sb_fan_ff ? fx : 26'(sb_dx_ff);
   assign offy = sb_fan_ff ? fy : 26'(sb_dy_ff);

   assign sumx = 33'(sb_x_ff) + 33'(offx);
   assign sumy = 33'(sb_y_ff) + 33'(offy);

   // Clamp to the signed 32-bit range when the sum overflows.
   always_comb begin
      satx = sumx[31:0];
      saty = sumy[31:0];
      if (sumx[32] != sumx[31]) begin
         satx = sumx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      if (sumy[32] != sumy[31]) begin
         saty = sumy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   end

   // ---------------- Result register ----------------
   logic signed [31:0] out_x_ff;
   logic signed [31:0] out_y_ff;
   logic [1:0]         out_kind_ff;
   logic               out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= sb_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff    <= satx;
         out_y_ff    <= saty;
         out_kind_ff <= sb_kind_ff;
         out_last_ff <= sb_last_ff;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_vert_x      = out_x_ff;
   assign rsp_vert_y      = out_y_ff;
   assign rsp_prim_kind   = out_kind_ff;
   assign rsp_last_vertex = out_last_ff;

endmodule

`default_nettype wire

FILE: hdl/marker_vertex_generator_top.sv
// Top level of the marker vertex generator: front end, marker queue and
// back end. Uses mvg_pkg, mvg_front, mvg_queue and mvg_back.
//
//   Channel   Direction  Handshake         Payload
//   req       in         req_valid/stall   point_x, point_y
//   rsp       out        rsp_valid/stall   vert_x, vert_y, prim_kind, last_vertex
//   csr       in/out     psel/penable      marker_type (0x0), marker_size (0x4)
//
// A marker has 1 vertex for a dot, 3 to 8 for lines and polygons, CIRCLE_SIDES
// for a circle, set by the back-end sequencer that issues one vertex per cycle
// while rsp is not stalled. Each vertex passes through stage A, stage B and the
// result register. A four-entry queue lets the input keep accepting while the
// back end works or rsp is stalled; a stall freezes the back end. Reset is
// synchronous and clears the registers, queue and pipeline valids.
`default_nettype none

module marker_vertex_generator_top #(
   parameter int CIRCLE_SIDES = mvg_pkg::CIRCLE_SIDES_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Configuration port
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   // Input channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [31:0]  req_point_x,
   input  wire logic signed [31:0]  req_point_y,
   // Result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_vert_x,
   output logic signed [31:0]       rsp_vert_y,
   output logic [1:0]               rsp_prim_kind,
   output logic                     rsp_last_vertex
);

   logic                  push;
   logic                  pop;
   logic                  queue_full;
   logic                  head_valid;
   mvg_pkg::mvg_item_type push_item;
   mvg_pkg::mvg_item_type head_item;
   mvg_pkg::mvg_cfg_type  cfg;

   // Accept and screen markers, hold configuration.
   mvg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item),
      .cfg         (cfg)
   );

   // Markers waiting for the back end.
   mvg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   // Expand each marker into its vertices.
   mvg_back #(
      .CIRCLE_SIDES (CIRCLE_SIDES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .head_valid      (head_valid),
      .pop             (pop),
      .cfg             (cfg),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_prim_kind   (rsp_prim_kind),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule

`default_nettype wire

FILE: hdl/mvg_checker.sv
// Port-level checks for the marker vertex generator, bound to the top level.
// Uses mvg_pkg and the macros in marker_vertex_generator_top_defines.svh.
`default_nettype none
`include "marker_vertex_generator_top_defines.svh"

module mvg_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_vert_x,
   input wire logic signed [31:0] rsp_vert_y,
   input wire logic [1:0]         rsp_prim_kind,
   input wire logic               rsp_last_vertex
);

   // No result is offered right after a reset cycle.
   `MVG_ASSERT_RESET(a_quiet_after_reset, reset, !rsp_valid, "result valid after reset")

   // A stalled vertex holds its coordinates.
   `MVG_ASSERT_NEXT(a_stall_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_vert_x) && $stable(rsp_vert_y), "stalled vertex changed")

   // A dot is a marker of its own: its single vertex closes it.
   `MVG_ASSERT_SAME(a_point_last, rsp_valid && (rsp_prim_kind == mvg_pkg::PK_POINT), rsp_last_vertex, "point vertex without last flag")

   // Vertices of one marker follow each other without gaps and share a kind.
   `MVG_ASSERT_NEXT(a_marker_contiguous, rsp_valid && !rsp_stall && !rsp_last_vertex, rsp_valid && $stable(rsp_prim_kind), "marker vertices interrupted")

   // The reserved kind code never appears.
   `MVG_ASSERT_SAME(a_kind_legal, rsp_valid, rsp_prim_kind != mvg_pkg::PK_RSVD, "reserved primitive kind")

endmodule

bind marker_vertex_generator_top mvg_checker u_mvg_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for marker_vertex_generator_top: every marker type is
// predicted vertex by vertex and compared in order. Depends on mvg_pkg and the RTL.
module tb;

   localparam int     CIRCLE_N         = mvg_pkg::CIRCLE_SIDES_DEFAULT;
   localparam int     CYCLE_LIMIT      = 500000;
   localparam int     SETTLE_CYCLES    = 64;
   localparam int     LONG_HOLD        = 400;
   localparam int     RAND_PHASES      = 16;
   localparam int     POINTS_PER_PHASE = 10;
   localparam longint INV_ROOT2_Q16    = 46348;
   localparam longint unsigned Q30     = 64'd1073741824;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   // Horner divisors, first term in the top byte.
   localparam logic [39:0] SIN_DIVS = {8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [47:0] COS_DIVS = {8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [1:0]  kind;
      logic        last;
   } vertex_type;

   // Predicts the vertices of each accepted marker and checks them in order.
   class vertex_scoreboard;
      logic [3:0]  mtype;
      logic [23:0] msize;
      vertex_type  pending[$];
      int          mismatches;
      int          compared;

      function new();
         mtype = mvg_pkg::MARKER_TYPE_RESET;
         msize = mvg_pkg::MARKER_SIZE_RESET;
         mismatches = 0;
         compared = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] value);
         if (idx == mvg_pkg::REG_MARKER_TYPE) begin
            mtype = value[3:0];
         end else begin
            msize = value[23:0];
         end
      endfunction

      function logic [31:0] clamp32(longint v);
         if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
         if (v < -64'sh8000_0000) return 32'h8000_0000;
         return v[31:0];
      endfunction

      function void add_vertex(longint vx, longint vy, logic [1:0] kind, logic last);
         vertex_type v;
         v.x = clamp32(vx);
         v.y = clamp32(vy);
         v.kind = kind;
         v.last = last;
         pending.push_back(v);
      endfunction

      // Truncated Taylor series in Q30, evaluated by Horner's rule.
      function longint unsigned series_q30(longint unsigned u2, bit want_cos);
         longint unsigned t;
         longint unsigned sub;
         longint unsigned d;
         int k;
         t = Q30;
         for (k = 0; k < (want_cos ? 6 : 5); k++) begin
            d = want_cos ? COS_DIVS[8*(5-k) +: 8] : SIN_DIVS[8*(4-k) +: 8];
            sub = ((u2 * t) >> 30) / d;
            t = (sub >= Q30) ? 0 : Q30 - sub;
         end
         return t;
      endfunction

      function int q15_of(longint unsigned v);
         longint unsigned r;
         r = (v + 16384) >> 15;
         return (r > 32767) ? 32767 : int'(r);
      endfunction

      // Q1.15 cosine and sine of fan vertex j out of n.
      function void fan_trig(int j, int n, output int cq, output int sq);
         longint unsigned p;
         longint unsigned u;
         longint unsigned u2;
         int c;
         int s;
         p = (2 * j + 1) * 65536;
         p = p / (2 * n);
         u = ((p & 16383) * QUARTER_TURN_Q30) >> 14;
         u2 = (u * u) >> 30;
         s = q15_of((u * series_q30(u2, 1'b0)) >> 30);
         c = q15_of(series_q30(u2, 1'b1));
         case (p[15:14])
            2'd0: begin
               cq = c;
               sq = s;
            end
            2'd1: begin
               cq = -s;
               sq = c;
            end
            2'd2: begin
               cq = -c;
               sq = -s;
            end
            default: begin
               cq = s;
               sq = -c;
            end
         endcase
      endfunction

      // Size times a Q1.15 value, rounded symmetrically about zero.
      function longint fan_offset(int trig);
         longint unsigned mag;
         longint unsigned sz;
         longint m;
         sz = msize;
         mag = (trig < 0) ? -trig : trig;
         m = (sz * mag + 16384) >> 15;
         return (trig < 0) ? -m : m;
      endfunction

      // Expected vertices of one accepted marker center.
      function void note_point(logic signed [31:0] px, logic signed [31:0] py);
         longint x;
         longint y;
         longint h;
         longint d;
         int n;
         int j;
         int cq;
         int sq;
         x = px;
         y = py;
         h = msize >> 1;
         d = (h * INV_ROOT2_Q16 + 32768) >>> 16;
         n = 0;
         case (mtype)
            mvg_pkg::MT_DOT: add_vertex(x, y, mvg_pkg::PK_POINT, 1'b1);
            mvg_pkg::MT_PLUS, mvg_pkg::MT_ASTERISK: begin
               add_vertex(x - h, y, mvg_pkg::PK_LINE, 1'b0);
               add_vertex(x + h, y, mvg_pkg::PK_LINE, 1'b0);
               add_vertex(x, y - h, mvg_pkg::PK_LINE, 1'b0);
               add_vertex(x, y + h, mvg_pkg::PK_LINE, mtype == mvg_pkg::MT_PLUS);
               if (mtype == mvg_pkg::MT_ASTERISK) begin
                  add_vertex(x - d, y + d, mvg_pkg::PK_LINE, 1'b0);
                  add_vertex(x + d, y - d, mvg_pkg::PK_LINE, 1'b0);
                  add_vertex(x - d, y - d, mvg_pkg::PK_LINE, 1'b0);
                  add_vertex(x + d, y + d, mvg_pkg::PK_LINE, 1'b1);
               end
            end
            mvg_pkg::MT_CROSS: begin
               add_vertex(x - h, y + h, mvg_pkg::PK_LINE, 1'b0);
               add_vertex(x + h, y - h, mvg_pkg::PK_LINE, 1'b0);
               add_vertex(x - h, y - h, mvg_pkg::PK_LINE, 1'b0);
               add_vertex(x + h, y + h, mvg_pkg::PK_LINE, 1'b1);
            end
            mvg_pkg::MT_CIRCLE:   n = CIRCLE_N;
            mvg_pkg::MT_TRIANGLE: n = 3;
            mvg_pkg::MT_SQUARE:   n = 4;
            mvg_pkg::MT_PENTAGON: n = 5;
            mvg_pkg::MT_HEXAGON:  n = 6;
            default: ;
         endcase
         for (j = 0; j < n; j++) begin
            fan_trig(j, n, cq, sq);
            add_vertex(x + fan_offset(cq), y + fan_offset(sq), mvg_pkg::PK_FAN,
                       j == n - 1);
         end
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         compared++;
         if (pending.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: unexpected vertex x=%h y=%h kind=%0d last=%b",
                        got.x, got.y, got.kind, got.last);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.kind !== want.kind ||
             got.last !== want.last) begin
            if (mismatches < 10) begin
               $display("ERROR: vertex %0d expected x=%h y=%h kind=%0d last=%b",
                        compared, want.x, want.y, want.kind, want.last);
               $display("       got      x=%h y=%h kind=%0d last=%b",
                        got.x, got.y, got.kind, got.last);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_vert_x;
   logic signed [31:0] rsp_vert_y;
   logic [1:0]         rsp_prim_kind;
   logic               rsp_last_vertex;

   vertex_scoreboard sb;
   vertex_type       got_vertex;
   bit               quiet = 1'b0;
   int               hold_requests = 0;
   int               holds_done = 0;
   int               cycles = 0;
   int               points_sent = 0;
   int               settings = 0;
   int               phase;
   int               hold_left;
   logic [3:0]       ptype;
   logic [23:0]      psize;

   marker_vertex_generator_top #(.CIRCLE_SIDES(CIRCLE_N)) uut (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_vert_x(rsp_vert_x),
      .rsp_vert_y(rsp_vert_y),
      .rsp_prim_kind(rsp_prim_kind),
      .rsp_last_vertex(rsp_last_vertex)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d vertices outstanding.",
                  cycles, sb.pending.size());
         $display("marker_vertex_generator_top: mismatch");
         $finish;
      end
   end

   // Result monitor: every accepted transaction is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_vertex.x = rsp_vert_x;
         got_vertex.y = rsp_vert_y;
         got_vertex.kind = rsp_prim_kind;
         got_vertex.last = rsp_last_vertex;
         sb.check_vertex(got_vertex);
      end
   end

   // Receiver: random stall bursts, free stretches and one long hold on request.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < hold_requests) begin
            holds_done++;
            rsp_stall <= 1'b1;
            for (hold_left = LONG_HOLD; hold_left > 0; hold_left--)
               @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 10)) @(posedge clock);
         end
      end
   end

   // Coordinates spread over the full range, near zero and near both limits.
   function automatic logic [31:0] rand_coord();
      logic [31:0] mag;
      mag = $urandom_range(0, 32'h0200_0000);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? -(mag >> 3) : (mag >> 3);
         2: return 32'h7FFF_FFFF - mag;
         default: return 32'h8000_0000 + mag;
      endcase
   endfunction

   // Offers one marker center and holds it until the transaction completes.
   task automatic send_point(logic [31:0] x, logic [31:0] y);
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (req_stall);
      sb.note_point(x, y);
      points_sent++;
   endtask

   // Stops the sender, waits for all results and lets the back end go quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic apply_setting(logic [3:0] mtype, logic [23:0] msize);
      drain();
      write_reg(mvg_pkg::REG_MARKER_TYPE, {28'd0, mtype});
      write_reg(mvg_pkg::REG_MARKER_SIZE, {8'd0, msize});
      settings++;
   endtask

   task automatic run_points(int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         send_point(rand_coord(), rand_coord());
      end
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_valid <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: dot markers at the coordinate extremes.
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'hFFFF_FFFF, 32'h0000_0001);

      // Full-scale size on every glyph but the dot, centered near a corner so sums saturate.
      for (ptype = mvg_pkg::MT_PLUS; ptype <= mvg_pkg::MT_HEXAGON; ptype++) begin
         apply_setting(ptype, 24'hFF_FFFF);
         send_point(32'h7FFF_0000, 32'h8001_0000);
      end

      // Unused type codes accept points but produce nothing.
      apply_setting('1, mvg_pkg::MARKER_SIZE_RESET);
      send_point(32'h1234_5678, 32'h8765_4321);
      send_point(32'h0000_0000, 32'hFFFF_FFFF);
      apply_setting(mvg_pkg::MT_HEXAGON + 4'd1, 24'hFF_FFFF);
      send_point(32'h0001_0000, 32'h0001_0000);

      // Zero size collapses every vertex onto the center.
      apply_setting(mvg_pkg::MT_CIRCLE, 24'd0);
      send_point(32'h0010_0000, 32'hFFF0_0000);
      apply_setting(mvg_pkg::MT_ASTERISK, 24'd0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);

      // A size of one truncates the half size to zero.
      apply_setting(mvg_pkg::MT_CROSS, 24'd1);
      send_point(32'h0001_0000, 32'hFFFF_0000);

      // Random phases: each glyph in turn first, then random settings.
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase <= mvg_pkg::MT_HEXAGON) begin
            ptype = mvg_pkg::MT_DOT + 4'(phase);
         end else if ($urandom_range(0, 3) == 0) begin
            ptype = $urandom_range(mvg_pkg::MT_HEXAGON + 1, 15);
         end else begin
            ptype = $urandom_range(mvg_pkg::MT_DOT, mvg_pkg::MT_HEXAGON);
         end
         case ($urandom_range(0, 3))
            0: psize = mvg_pkg::MARKER_SIZE_RESET;
            1: psize = $urandom_range(0, 24'h0F_FFFF);
            2: psize = $urandom;
            default: psize = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0;
         endcase
         apply_setting(ptype, psize);
         quiet = (phase >= RAND_PHASES - 3);
         // Circle phase: hold results back long enough to fill the queue.
         if (ptype == mvg_pkg::MT_CIRCLE && !quiet)
            hold_requests++;
         run_points(POINTS_PER_PHASE);
      end

      drain();
      $display("Sent %0d marker centers under %0d register settings; compared %0d vertices.",
               points_sent, settings, sb.compared);
      $display("Covered every glyph, unused codes, zero and full-scale size, saturation and backpressure.");
      if (sb.mismatches == 0) begin
         $display("marker_vertex_generator_top: match");
      end else begin
         $display("marker_vertex_generator_top: mismatch");
      end
      $finish;
   end
endmodule
